[hdl/pcx_rle_pkg.sv]
// shared types and constants for the pcx run-length image decoder
// no dependencies; compile before every other file
`default_nettype none

package pcx_rle_pkg;

  // widths of the data paths
  localparam int DataW    = 8;
  localparam int ValueW   = 24;
  localparam int RunW     = 6;
  localparam int DimW     = 16;
  localparam int PixW     = 32;
  localparam int PalCntW  = 9;
  localparam int TripleW  = 2;
  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 32;

  // command queue between front and back
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = 2;
  localparam int FifoCntW  = 3;

  // run marker: top two bits of the byte set
  localparam logic [DataW-1:0] RunMarkMask = 8'hC0;

  // palette sizes, one bit wider than the entry counter
  localparam logic [PalCntW:0] PalSmall = 10'd16;
  localparam logic [PalCntW:0] PalLarge = 10'd256;

  // byte position of the blue component within a triple
  localparam logic [TripleW-1:0] TripleBlue = 2'd2;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegPal256 = 2'd2;

  // decode phase
  typedef enum logic [1:0] {
    PH_PIXEL   = 2'd0,
    PH_PALETTE = 2'd1,
    PH_DONE    = 2'd2
  } phase_t;

  // settings seen by the front end
  typedef struct packed {
    logic [PixW-1:0] total;
    logic            palette_256;
  } cfg_t;

  // one queued job: emit value count times, flag the final one if last
  typedef struct packed {
    logic              is_palette;
    logic [ValueW-1:0] value;
    logic [RunW-1:0]   count;
    logic              last;
  } cmd_t;

endpackage

`default_nettype wire

[hdl/pcx_rle_if.sv]
// valid/ready stream interfaces for payload bytes and decoded results
// uses pcx_rle_pkg for field widths
`default_nettype none

interface pcx_rle_byte_if;
  logic                           valid;
  logic                           ready;
  logic [pcx_rle_pkg::DataW-1:0]  data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface pcx_rle_res_if;
  logic                           valid;
  logic                           ready;
  logic                           is_palette;
  logic [pcx_rle_pkg::ValueW-1:0] value;
  logic                           entry_last;

  modport source (output valid, output is_palette, output value, output entry_last,
                  input ready);
  modport sink   (input valid, input is_palette, input value, input entry_last,
                  output ready);
endinterface

`default_nettype wire

[hdl/pcx_rle_cfg.sv]
// apb register block: image size, palette mode and the registered pixel total
// uses pcx_rle_pkg
`default_nettype none

module pcx_rle_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [pcx_rle_pkg::CfgAddrW-1:0]    paddr,
  input  wire logic [pcx_rle_pkg::CfgDataW-1:0]    pwdata,
  output logic      [pcx_rle_pkg::CfgDataW-1:0]    prdata,
  output logic                                     pready,
  output pcx_rle_pkg::cfg_t                        cfg
);

  logic [pcx_rle_pkg::DimW-1:0] image_width;
  logic [pcx_rle_pkg::DimW-1:0] image_height;
  logic                         palette_256;
  logic [pcx_rle_pkg::PixW-1:0] total;

  logic                         wr;
  logic [1:0]                   idx;
  logic [pcx_rle_pkg::DimW-1:0] mul_a;
  logic [pcx_rle_pkg::DimW-1:0] mul_b;
  logic [pcx_rle_pkg::PixW-1:0] product;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  // one multiplier: new dimension times the other stored one
  always_comb begin
    mul_a = image_width;
    mul_b = image_height;
    if (idx == pcx_rle_pkg::RegWidth) begin
      mul_a = pwdata[pcx_rle_pkg::DimW-1:0];
    end else if (idx == pcx_rle_pkg::RegHeight) begin
      mul_b = pwdata[pcx_rle_pkg::DimW-1:0];
    end
  end

  assign product = pcx_rle_pkg::PixW'(mul_a) * pcx_rle_pkg::PixW'(mul_b);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= pcx_rle_pkg::DimW'(1);
      image_height <= pcx_rle_pkg::DimW'(1);
      palette_256  <= 1'b0;
      total        <= pcx_rle_pkg::PixW'(1);
    end else if (wr) begin
      case (idx)
        pcx_rle_pkg::RegWidth: begin
          image_width <= pwdata[pcx_rle_pkg::DimW-1:0];
          total       <= product;
        end
        pcx_rle_pkg::RegHeight: begin
          image_height <= pwdata[pcx_rle_pkg::DimW-1:0];
          total        <= product;
        end
        pcx_rle_pkg::RegPal256: begin
          palette_256 <= pwdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      pcx_rle_pkg::RegWidth:  prdata = pcx_rle_pkg::CfgDataW'(image_width);
      pcx_rle_pkg::RegHeight: prdata = pcx_rle_pkg::CfgDataW'(image_height);
      pcx_rle_pkg::RegPal256: prdata = pcx_rle_pkg::CfgDataW'(palette_256);
      default:                prdata = '0;
    endcase
  end

  assign cfg.total       = total;
  assign cfg.palette_256 = palette_256;

endmodule

`default_nettype wire

[hdl/pcx_rle_front.sv]
// front end: takes payload bytes, tracks phase, runs and palette triples,
// and queues one emit job per byte that produces output; uses pcx_rle_pkg
`default_nettype none

module pcx_rle_front (
  input  wire logic               clk,
  input  wire logic               rst,
  pcx_rle_byte_if.sink            data,
  input  pcx_rle_pkg::cfg_t       cfg,
  output pcx_rle_pkg::cmd_t       cmd,
  output logic                    cmd_push,
  input  wire logic               cmd_full
);

  pcx_rle_pkg::phase_t phase, phase_next, eff_phase;

  logic                            run_pending, run_pending_next;
  logic [pcx_rle_pkg::RunW-1:0]    run_length, run_length_next;
  logic [pcx_rle_pkg::PixW-1:0]    pixels_done, pixels_done_next;
  logic [2*pcx_rle_pkg::DataW-1:0] color_bytes, color_bytes_next;
  logic [pcx_rle_pkg::TripleW-1:0] byte_in_triple, byte_in_triple_next;
  logic [pcx_rle_pkg::PalCntW-1:0] palette_count, palette_count_next;

  logic                            accept;
  logic [pcx_rle_pkg::DataW-1:0]   b;
  logic [pcx_rle_pkg::PixW:0]      diff;
  logic [pcx_rle_pkg::PixW-1:0]    remain;
  logic                            pix_over;
  logic                            marker;
  logic [pcx_rle_pkg::RunW-1:0]    n_req;
  logic                            clipped;
  logic [pcx_rle_pkg::RunW-1:0]    n_eff;
  logic [pcx_rle_pkg::PalCntW:0]   entries;
  logic                            pal_last;
  logic                            blue_byte;

  assign data.ready = ~cmd_full;
  assign accept     = data.valid & ~cmd_full;
  assign b          = data.data_byte;

  // pixels left; a borrow means the size was lowered below the count
  assign diff     = {1'b0, cfg.total} - {1'b0, pixels_done};
  assign remain   = diff[pcx_rle_pkg::PixW-1:0];
  assign pix_over = diff[pcx_rle_pkg::PixW] | (remain == '0);

  assign eff_phase = (phase == pcx_rle_pkg::PH_PIXEL && pix_over) ?
                     pcx_rle_pkg::PH_PALETTE : phase;

  // byte classification and run clipping
  assign marker  = (b & pcx_rle_pkg::RunMarkMask) == pcx_rle_pkg::RunMarkMask;
  assign n_req   = run_pending ? run_length : pcx_rle_pkg::RunW'(1);
  assign clipped = (remain[pcx_rle_pkg::PixW-1:pcx_rle_pkg::RunW] == '0) &&
                   (remain[pcx_rle_pkg::RunW-1:0] <= n_req);
  assign n_eff   = clipped ? remain[pcx_rle_pkg::RunW-1:0] : n_req;

  // palette entry bookkeeping
  assign entries   = cfg.palette_256 ? pcx_rle_pkg::PalLarge : pcx_rle_pkg::PalSmall;
  assign pal_last  = ({1'b0, palette_count} + 10'd1) >= entries;
  assign blue_byte = (byte_in_triple >= pcx_rle_pkg::TripleBlue);

  // next phase
  always_comb begin
    phase_next = phase;
    if (accept) begin
      case (eff_phase)
        pcx_rle_pkg::PH_PIXEL: begin
          if ((run_pending || !marker) && clipped) begin
            phase_next = pcx_rle_pkg::PH_PALETTE;
          end
        end
        pcx_rle_pkg::PH_PALETTE: begin
          phase_next = (blue_byte && pal_last) ? pcx_rle_pkg::PH_DONE :
                                                 pcx_rle_pkg::PH_PALETTE;
        end
        default: begin
        end
      endcase
    end
  end

  // datapath and queue writes
  always_comb begin
    run_pending_next    = run_pending;
    run_length_next     = run_length;
    pixels_done_next    = pixels_done;
    color_bytes_next    = color_bytes;
    byte_in_triple_next = byte_in_triple;
    palette_count_next  = palette_count;
    cmd_push            = 1'b0;
    cmd                 = '0;
    if (accept) begin
      case (eff_phase)
        pcx_rle_pkg::PH_PIXEL: begin
          if (!run_pending && marker) begin
            run_pending_next = 1'b1;
            run_length_next  = b[pcx_rle_pkg::RunW-1:0];
          end else begin
            run_pending_next = 1'b0;
            run_length_next  = '0;
            pixels_done_next = clipped ? cfg.total :
                               pixels_done + pcx_rle_pkg::PixW'(n_req);
            cmd_push         = (n_eff != '0);
            cmd.is_palette   = 1'b0;
            cmd.value        = pcx_rle_pkg::ValueW'(b);
            cmd.count        = n_eff;
            cmd.last         = clipped;
          end
        end
        pcx_rle_pkg::PH_PALETTE: begin
          run_pending_next = 1'b0;
          run_length_next  = '0;
          if (!blue_byte) begin
            color_bytes_next    = {color_bytes[pcx_rle_pkg::DataW-1:0], b};
            byte_in_triple_next = byte_in_triple + pcx_rle_pkg::TripleW'(1);
          end else begin
            cmd_push            = 1'b1;
            cmd.is_palette      = 1'b1;
            cmd.value           = {color_bytes, b};
            cmd.count           = pcx_rle_pkg::RunW'(1);
            cmd.last            = pal_last;
            color_bytes_next    = '0;
            byte_in_triple_next = '0;
            palette_count_next  = palette_count + pcx_rle_pkg::PalCntW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= pcx_rle_pkg::PH_PIXEL;
      run_pending    <= 1'b0;
      run_length     <= '0;
      pixels_done    <= '0;
      color_bytes    <= '0;
      byte_in_triple <= '0;
      palette_count  <= '0;
    end else begin
      phase          <= phase_next;
      run_pending    <= run_pending_next;
      run_length     <= run_length_next;
      pixels_done    <= pixels_done_next;
      color_bytes    <= color_bytes_next;
      byte_in_triple <= byte_in_triple_next;
      palette_count  <= palette_count_next;
    end
  end

  // a triple never runs past its blue byte
  assert property (@(posedge clk) disable iff (rst)
    byte_in_triple <= pcx_rle_pkg::TripleBlue)
    else $error("palette byte position out of range");

  // a queued pixel job ending the image moves the front to the palette
  assert property (@(posedge clk) disable iff (rst)
    (cmd_push && !cmd.is_palette && cmd.last) |=> (phase == pcx_rle_pkg::PH_PALETTE))
    else $error("last pixel queued but phase did not advance");

endmodule

`default_nettype wire

[hdl/pcx_rle_cmd_fifo.sv]
// short flop queue of emit jobs between front and back end
// uses pcx_rle_pkg
`default_nettype none

module pcx_rle_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  pcx_rle_pkg::cmd_t  push_cmd,
  output logic               full,
  input  wire logic          pop,
  output pcx_rle_pkg::cmd_t  pop_cmd,
  output logic               empty
);

  pcx_rle_pkg::cmd_t                mem [pcx_rle_pkg::FifoDepth];
  logic [pcx_rle_pkg::FifoPtrW-1:0] wr_ptr;
  logic [pcx_rle_pkg::FifoPtrW-1:0] rd_ptr;
  logic [pcx_rle_pkg::FifoCntW-1:0] count;

  assign full    = (count == pcx_rle_pkg::FifoCntW'(pcx_rle_pkg::FifoDepth));
  assign empty   = (count == '0);
  assign pop_cmd = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + pcx_rle_pkg::FifoPtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + pcx_rle_pkg::FifoPtrW'(1);
      end
      if (push && !pop) begin
        count <= count + pcx_rle_pkg::FifoCntW'(1);
      end else if (pop && !push) begin
        count <= count - pcx_rle_pkg::FifoCntW'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("job queue overflow");

  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("job queue underflow");

endmodule

`default_nettype wire

[hdl/pcx_rle_back.sv]
// back end: expands queued jobs into result words, one per cycle while the output
// is taken, through an output register; uses pcx_rle_pkg and pcx_rle_res_if
`default_nettype none

module pcx_rle_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  pcx_rle_pkg::cmd_t  cmd,
  input  wire logic          cmd_empty,
  output logic               cmd_pop,
  pcx_rle_res_if.source      result
);

  logic                           work_valid;
  logic [pcx_rle_pkg::RunW-1:0]   work_cnt;
  logic                           work_pal;
  logic [pcx_rle_pkg::ValueW-1:0] work_value;
  logic                           work_last;

  logic                           out_valid;
  logic                           out_pal;
  logic [pcx_rle_pkg::ValueW-1:0] out_value;
  logic                           out_last;

  logic                           out_load;
  logic                           emit;
  logic                           work_done;

  // output register frees when empty or taken this cycle
  assign out_load  = ~out_valid | result.ready;
  assign emit      = work_valid & out_load;
  assign work_done = emit & (work_cnt == pcx_rle_pkg::RunW'(1));
  assign cmd_pop   = ~cmd_empty & (~work_valid | work_done);

  // current job
  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
      work_cnt   <= '0;
    end else if (cmd_pop) begin
      work_valid <= 1'b1;
      work_cnt   <= cmd.count;
    end else if (work_done) begin
      work_valid <= 1'b0;
      work_cnt   <= '0;
    end else if (emit) begin
      work_cnt <= work_cnt - pcx_rle_pkg::RunW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      work_pal   <= cmd.is_palette;
      work_value <= cmd.value;
      work_last  <= cmd.last;
    end
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output word payload; only the final copy of a job carries the flag
  always_ff @(posedge clk) begin
    if (emit) begin
      out_pal   <= work_pal;
      out_value <= work_value;
      out_last  <= work_last & (work_cnt == pcx_rle_pkg::RunW'(1));
    end
  end

  assign result.valid      = out_valid;
  assign result.is_palette = out_pal;
  assign result.value      = out_value;
  assign result.entry_last = out_last;

  assert property (@(posedge clk) disable iff (rst) cmd_pop |-> (cmd.count != '0))
    else $error("empty job reached the back end");

  assert property (@(posedge clk) disable iff (rst) work_valid |-> (work_cnt != '0))
    else $error("active job with no words left");

endmodule

`default_nettype wire

[hdl/pcx_rle_image_decoder.sv]
// pcx run-length decoder: one payload byte per cycle for literal and palette
// bytes; a run of n pixels becomes n back-end words, and the input stalls
// once the four-job queue fills. a byte's words pass the job queue, the job
// and output registers. synchronous active-high reset clears phase, counters,
// queue and output; registers return to width 1, height 1, 16-entry palette.
`default_nettype none

module pcx_rle_image_decoder (
  input  wire logic                                clk,
  input  wire logic                                rst,
  pcx_rle_byte_if.sink                             data,
  pcx_rle_res_if.source                            result,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [pcx_rle_pkg::CfgAddrW-1:0]    paddr,
  input  wire logic [pcx_rle_pkg::CfgDataW-1:0]    pwdata,
  output logic      [pcx_rle_pkg::CfgDataW-1:0]    prdata,
  output logic                                     pready
);

  pcx_rle_pkg::cfg_t cfg;
  pcx_rle_pkg::cmd_t push_cmd;
  pcx_rle_pkg::cmd_t pop_cmd;
  logic              push;
  logic              full;
  logic              pop;
  logic              empty;

  // configuration registers
  pcx_rle_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // byte classification
  pcx_rle_front u_front (
    .clk      (clk),
    .rst      (rst),
    .data     (data),
    .cfg      (cfg),
    .cmd      (push_cmd),
    .cmd_push (push),
    .cmd_full (full)
  );

  // job queue
  pcx_rle_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (empty)
  );

  // result expansion
  pcx_rle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (pop_cmd),
    .cmd_empty (empty),
    .cmd_pop   (pop),
    .result    (result)
  );

endmodule

`default_nettype wire

[tb/tb_pcx_rle_image_decoder.sv]
// self-checking testbench for the pcx run-length image decoder
// needs pcx_rle_pkg, the stream interfaces in pcx_rle_if.sv and the decoder itself
`timescale 1ns / 100ps

module tb_pcx_rle_image_decoder;

  localparam int CycleLimit = 3_000_000;
  localparam int HoldAfter  = 300;
  localparam int HoldCycles = 500;

  // one decoded result word
  typedef struct packed {
    logic                           is_palette;
    logic [pcx_rle_pkg::ValueW-1:0] value;
    logic                           entry_last;
  } word_t;

  // directed row: payload byte, and when typed the number of pixel words it yields
  typedef struct packed {
    logic [pcx_rle_pkg::DataW-1:0] data;
    logic                          typed;
    logic [pcx_rle_pkg::RunW-1:0]  count;
  } row_t;

  localparam int NumRows = 20;
  localparam row_t DirectedRows [0:NumRows-1] = '{
    '{8'h00, 1'b1, 6'd1},   // smallest literal
    '{8'hBF, 1'b1, 6'd1},   // largest literal
    '{8'h3F, 1'b1, 6'd1},
    '{8'h80, 1'b1, 6'd1},
    '{8'h7F, 1'b1, 6'd1},
    '{8'h40, 1'b1, 6'd1},
    '{8'hC0, 1'b1, 6'd0},   // zero-length run marker
    '{8'h55, 1'b1, 6'd0},   // swallowed by the empty run
    '{8'hC0, 1'b1, 6'd0},
    '{8'hFF, 1'b1, 6'd0},   // marker-like byte swallowed as run data
    '{8'hFF, 1'b1, 6'd0},   // longest run marker
    '{8'hFF, 1'b1, 6'd63},
    '{8'hC1, 1'b1, 6'd0},
    '{8'hC0, 1'b1, 6'd1},   // marker value repeated as a pixel
    '{8'hE5, 1'b0, 6'd0},
    '{8'h12, 1'b0, 6'd0},
    '{8'hC2, 1'b0, 6'd0},
    '{8'h00, 1'b0, 6'd0},
    '{8'hAA, 1'b0, 6'd0},
    '{8'h01, 1'b0, 6'd0}
  };

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [pcx_rle_pkg::CfgAddrW-1:0] paddr;
  logic [pcx_rle_pkg::CfgDataW-1:0] pwdata;
  logic [pcx_rle_pkg::CfgDataW-1:0] prdata;
  logic                             pready;

  pcx_rle_byte_if byte_ch ();
  pcx_rle_res_if  word_ch ();

  pcx_rle_image_decoder dut (
    .clk     (clk),
    .rst     (rst),
    .data    (byte_ch),
    .result  (word_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // decoder copy: settings and state
  logic [pcx_rle_pkg::DimW-1:0]    cfg_width;
  logic [pcx_rle_pkg::DimW-1:0]    cfg_height;
  logic                            cfg_pal256;
  pcx_rle_pkg::phase_t             dec_phase;
  logic                            run_armed;
  logic [pcx_rle_pkg::RunW-1:0]    run_count;
  logic [pcx_rle_pkg::PixW-1:0]    pix_count;
  logic [15:0]                     rgb_acc;
  logic [pcx_rle_pkg::TripleW-1:0] triple_pos;
  logic [pcx_rle_pkg::PalCntW-1:0] entry_count;

  word_t step_words[$];
  word_t expected_words[$];
  int    errors     = 0;
  int    words_seen = 0;
  bit    send_quiet = 1'b0;
  bit    recv_quiet = 1'b0;

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // words caused by one accepted payload byte, left in step_words
  function automatic void decode_byte(logic [pcx_rle_pkg::DataW-1:0] b);
    logic [pcx_rle_pkg::PixW-1:0]  total;
    logic [pcx_rle_pkg::PixW-1:0]  remain;
    logic [pcx_rle_pkg::PalCntW:0] entries;
    logic                          last;
    int unsigned                   n;
    step_words.delete();
    total = pcx_rle_pkg::PixW'(cfg_width) * pcx_rle_pkg::PixW'(cfg_height);
    if (dec_phase == pcx_rle_pkg::PH_PIXEL && pix_count >= total) begin
      dec_phase = pcx_rle_pkg::PH_PALETTE;
      run_armed = 1'b0;
      run_count = '0;
    end
    // palette: red and green collect, blue completes the entry
    if (dec_phase == pcx_rle_pkg::PH_PALETTE) begin
      entries = cfg_pal256 ? pcx_rle_pkg::PalLarge : pcx_rle_pkg::PalSmall;
      if (triple_pos != pcx_rle_pkg::TripleBlue) begin
        rgb_acc    = {rgb_acc[7:0], b};
        triple_pos = triple_pos + 1'b1;
      end else begin
        last = ({1'b0, entry_count} + 1'b1) >= entries;
        step_words.push_back(word_t'{1'b1, {rgb_acc, b}, last});
        rgb_acc     = '0;
        triple_pos  = '0;
        entry_count = entry_count + 1'b1;
        if (last) dec_phase = pcx_rle_pkg::PH_DONE;
      end
      return;
    end
    if (dec_phase != pcx_rle_pkg::PH_PIXEL) return;
    // pixels: marker arms a run, next byte is repeated
    remain = total - pix_count;
    if (run_armed) begin
      n         = run_count;
      run_armed = 1'b0;
      run_count = '0;
    end else if ((b & pcx_rle_pkg::RunMarkMask) == pcx_rle_pkg::RunMarkMask) begin
      run_armed = 1'b1;
      run_count = b[pcx_rle_pkg::RunW-1:0];
      return;
    end else begin
      n = 1;
    end
    if (n > remain) n = remain;
    for (int unsigned i = 0; i < n; i++)
      step_words.push_back(word_t'{1'b0, {16'h0, b}, (i + 1 == remain)});
    pix_count = pix_count + n;
    if (pix_count >= total) dec_phase = pcx_rle_pkg::PH_PALETTE;
  endfunction

  // offer one byte after a random gap; typed rows replace the predicted words
  task automatic send_byte(logic [pcx_rle_pkg::DataW-1:0] b, logic typed,
                           logic [pcx_rle_pkg::RunW-1:0] count);
    int gap;
    if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    do @(posedge clk); while (!(byte_ch.valid && byte_ch.ready));
    decode_byte(b);
    if (typed) begin
      step_words.delete();
      repeat (count) step_words.push_back(word_t'{1'b0, {16'h0, b}, 1'b0});
    end
    foreach (step_words[i]) expected_words.push_back(step_words[i]);
  endtask

  function automatic logic [pcx_rle_pkg::DataW-1:0] draw_pixel_byte();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(8'hC0, 8'hFF));
    return 8'($urandom_range(8'h00, 8'hBF));
  endfunction

  // stop offering and wait for every expected word, then for stragglers
  task automatic drain();
    byte_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic reg_read(logic [1:0] idx, output logic [pcx_rle_pkg::CfgDataW-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write a register with junk in the unused upper bits, then read it back
  task automatic reg_write(logic [1:0] idx, logic [pcx_rle_pkg::DimW-1:0] val);
    logic [pcx_rle_pkg::CfgDataW-1:0] junk;
    logic [pcx_rle_pkg::CfgDataW-1:0] rd;
    logic [pcx_rle_pkg::DimW-1:0]     kept;
    junk    = $urandom;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk[31:16], val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      pcx_rle_pkg::RegWidth:  cfg_width  = val;
      pcx_rle_pkg::RegHeight: cfg_height = val;
      pcx_rle_pkg::RegPal256: cfg_pal256 = val[0];
      default: ;
    endcase
    kept = (idx == pcx_rle_pkg::RegPal256) ? pcx_rle_pkg::DimW'(val[0]) : val;
    reg_read(idx, rd);
    check_field("register readback", 32'(kept), rd);
  endtask

  // result side: random stalls, one long hold-off, compare against oldest word
  initial begin
    word_t want;
    int    stall;
    bit    held;
    held = 1'b0;
    word_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
      stall = recv_quiet ? 0 : $urandom_range(0, 19);
      if (!held && words_seen >= HoldAfter) begin
        stall = HoldCycles;
        held  = 1'b1;
      end
      if (stall > 0) begin
        word_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      word_ch.ready <= 1'b1;
      do @(posedge clk); while (!(word_ch.valid && word_ch.ready));
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: value 0x%0h", word_ch.value);
        errors++;
      end else begin
        want = expected_words.pop_front();
        check_field("is_palette", 32'(want.is_palette), 32'(word_ch.is_palette));
        check_field("value", 32'(want.value), 32'(word_ch.value));
        check_field("entry_last", 32'(want.entry_last), 32'(word_ch.entry_last));
      end
      words_seen++;
    end
  end

  // watchdog
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [pcx_rle_pkg::CfgDataW-1:0] rd;
    logic [pcx_rle_pkg::PixW-1:0]     target;
    int unsigned                      k;
    int unsigned                      n_entries;

    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= '0;
    cfg_width   = 16'd1;
    cfg_height  = 16'd1;
    cfg_pal256  = 1'b0;
    dec_phase   = pcx_rle_pkg::PH_PIXEL;
    run_armed   = 1'b0;
    run_count   = '0;
    pix_count   = '0;
    rgb_acc     = '0;
    triple_pos  = '0;
    entry_count = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers after reset
    reg_read(pcx_rle_pkg::RegWidth, rd);
    check_field("image_width", 32'd1, rd);
    reg_read(pcx_rle_pkg::RegHeight, rd);
    check_field("image_height", 32'd1, rd);
    reg_read(pcx_rle_pkg::RegPal256, rd);
    check_field("palette_256", 32'd0, rd);

    // largest image so the pixel phase lasts, large palette
    reg_write(pcx_rle_pkg::RegWidth, 16'hFFFF);
    reg_write(pcx_rle_pkg::RegHeight, 16'hFFFF);
    reg_write(pcx_rle_pkg::RegPal256, 16'd1);

    for (int r = 0; r < NumRows; r++)
      send_byte(DirectedRows[r].data, DirectedRows[r].typed, DirectedRows[r].count);

    // random pixel stream, with one pause until all words are out
    for (int i = 0; i < 300; i++) begin
      if (i == 150) drain();
      send_byte(draw_pixel_byte(), 1'b0, '0);
    end
    if (run_armed) send_byte(8'($urandom), 1'b0, '0);
    drain();

    // end of image: either an oversized run past a shrunk size, or the size
    // dropped below what is already done
    k      = $urandom_range(1, 62);
    target = pix_count + k;
    if ($urandom_range(0, 1) == 0 && target <= 32'hFFFF) begin
      if ($urandom_range(0, 1) == 0) begin
        reg_write(pcx_rle_pkg::RegWidth, target[15:0]);
        reg_write(pcx_rle_pkg::RegHeight, 16'd1);
      end else begin
        reg_write(pcx_rle_pkg::RegWidth, 16'd1);
        reg_write(pcx_rle_pkg::RegHeight, target[15:0]);
      end
      send_byte(8'hFF, 1'b0, '0);
      send_byte(8'($urandom), 1'b0, '0);
    end else begin
      reg_write(pcx_rle_pkg::RegWidth, 16'd1);
      reg_write(pcx_rle_pkg::RegHeight, 16'd1);
    end

    // palette entries, stopping at a triple boundary or at a random point inside a triple
    n_entries = $urandom_range(25, 40);
    repeat (3 * n_entries + $urandom_range(0, 2)) send_byte(8'($urandom), 1'b0, '0);
    drain();

    // shrink the palette mid-way: the next full entry ends it
    reg_write(pcx_rle_pkg::RegPal256, 16'd0);
    while (dec_phase != pcx_rle_pkg::PH_DONE) send_byte(8'($urandom), 1'b0, '0);

    // done phase swallows everything
    repeat (10) send_byte(8'($urandom), 1'b0, '0);
    drain();
    repeat (20) @(posedge clk);

    if (errors == 0 && expected_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
